[hdl/pba_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and digit helpers for the packed decimal arithmetic unit
// no dependencies

package pba_pkg;

    localparam int MAX_BYTES  = 8;
    localparam int DATA_W     = 8 * MAX_BYTES;
    localparam int IDX_W      = 3;
    localparam int NB_W       = 4;
    localparam int MULT_W     = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [NB_W-1:0] NUM_BYTES_RESET = 4'd5;

    // register word select, taken from paddr[2]
    localparam logic REG_NUM_BYTES = 1'b0;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_CMP = 2'd3
    } cmd_t;

    localparam logic signed [1:0] ORD_LESS    = -2'sd1;
    localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
    localparam logic signed [1:0] ORD_GREATER = 2'sd1;

    // control into the byte unit
    typedef struct packed {
        logic is_sub;
        logic cin;
    } byte_ctrl_t;

    // status out of the byte unit
    typedef struct packed {
        logic cout;
        logic gt;
        logic lt;
    } byte_stat_t;

    // bytes in use, clamped to 1..MAX_BYTES
    function automatic logic [IDX_W:0] used_bytes(input logic [NB_W-1:0] nb);
        logic [IDX_W:0] n;
        begin
            if (nb == '0)
                n = (IDX_W+1)'(1);
            else if ({1'b0, nb} > (NB_W+1)'(MAX_BYTES))
                n = (IDX_W+1)'(MAX_BYTES);
            else
                n = (IDX_W+1)'(nb);
            return n;
        end
    endfunction

    // keep mask over the bytes in use
    function automatic logic [DATA_W-1:0] keep_mask(input logic [IDX_W:0] n);
        logic [DATA_W-1:0] m;
        begin
            for (int i = 0; i < MAX_BYTES; i++)
                m[8*i +: 8] = ((IDX_W+1)'(i) < n) ? 8'hFF : 8'h00;
            return m;
        end
    endfunction

    // one decimal digit add or subtract, returns {carry, digit}
    function automatic logic [4:0] digit_op(
        input logic       is_sub,
        input logic [3:0] da,
        input logic [3:0] db,
        input logic       cin
    );
        logic [5:0] t;
        logic [5:0] adj;
        logic       c;
        begin
            if (is_sub)
            begin
                t   = {2'b00, da} - {2'b00, db} - {5'b0, cin};
                c   = t[5];
                adj = t + 6'd10;
            end
            else
            begin
                t   = {2'b00, da} + {2'b00, db} + {5'b0, cin};
                c   = (t >= 6'd10);
                adj = t - 6'd10;
            end
            return c ? {1'b1, adj[3:0]} : {1'b0, t[3:0]};
        end
    endfunction

endpackage

[hdl/pba_in_if.sv]
`timescale 1ns / 1ps
// input item channel: valid/ready handshake with command and operands
// depends on pba_pkg

interface pba_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [pba_pkg::DATA_W-1:0]    operand_a;
    logic [pba_pkg::DATA_W-1:0]    operand_b;
    logic [pba_pkg::MULT_W-1:0]    multiplier;

    modport source (output valid, cmd, operand_a, operand_b, multiplier, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, multiplier, output ready);
endinterface

[hdl/pba_out_if.sv]
`timescale 1ns / 1ps
// result item channel: valid/ready handshake with result value and order
// depends on pba_pkg

interface pba_out_if;
    logic                          valid;
    logic                          ready;
    logic [pba_pkg::DATA_W-1:0]    result_value;
    logic signed [1:0]             order;

    modport source (output valid, result_value, order, input ready);
    modport sink   (input valid, result_value, order, output ready);
endinterface

[hdl/pba_byte_unit.sv]
`timescale 1ns / 1ps
// shared byte unit: two-digit decimal add or subtract with chained carry,
// plus unsigned byte compare; depends on pba_pkg

module pba_byte_unit (
    input  logic [7:0]            x,
    input  logic [7:0]            y,
    input  pba_pkg::byte_ctrl_t   ctrl,
    output logic [7:0]            sum,
    output pba_pkg::byte_stat_t   stat
);

    logic [4:0] lo;
    logic [4:0] hi;

    // low digit then high digit, carry chained through
    always_comb
    begin
        lo = pba_pkg::digit_op(ctrl.is_sub, x[3:0], y[3:0], ctrl.cin);
        hi = pba_pkg::digit_op(ctrl.is_sub, x[7:4], y[7:4], lo[4]);
        sum       = {hi[3:0], lo[3:0]};
        stat.cout = hi[4];
        stat.gt   = (x > y);
        stat.lt   = (x < y);
    end

endmodule

[hdl/packed_bcd_arith_unit.sv]
`timescale 1ns / 1ps
// packed decimal arithmetic unit: add, subtract, multiply by repeated add, compare
// add, subtract and compare make one pass over the n bytes in use; multiply makes
//   multiplier-1 passes, none for multiply by 0 or 1
// one byte a cycle goes through the shared byte unit; one item in flight at a time
// the next item is taken once the last one is handed over, also while its result waits
// rst_n is asynchronous, active low; num_bytes resets to 5, no item or result pending

module packed_bcd_arith_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    pba_in_if.sink                        item_in,
    pba_out_if.source                     item_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pba_pkg::PADDR_W-1:0]   paddr,
    input  logic [pba_pkg::PDATA_W-1:0]   pwdata,
    output logic [pba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                          state_reg, state_next;
    logic [pba_pkg::NB_W-1:0]        num_bytes_reg, num_bytes_next;
    logic [1:0]                      cmd_reg, cmd_next;
    logic [pba_pkg::DATA_W-1:0]      acc_reg, acc_next;
    logic [pba_pkg::DATA_W-1:0]      opb_reg, opb_next;
    logic [pba_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic                            carry_reg, carry_next;
    logic [pba_pkg::MULT_W-1:0]      passes_reg, passes_next;
    logic signed [1:0]               ord_reg, ord_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pba_pkg::DATA_W-1:0]      out_value_reg, out_value_next;
    logic signed [1:0]               out_order_reg, out_order_next;

    logic [pba_pkg::IDX_W:0]         n_used;
    logic [pba_pkg::IDX_W-1:0]       last_idx;
    logic [pba_pkg::DATA_W-1:0]      mask;
    logic                            cfg_write;
    logic                            in_fire;
    logic                            out_free;
    logic [7:0]                      unit_x;
    logic [7:0]                      unit_y;
    logic [7:0]                      unit_sum;
    pba_pkg::byte_ctrl_t             unit_ctrl;
    pba_pkg::byte_stat_t             unit_stat;

    // byte count in use and operand mask
    always_comb
    begin
        n_used   = pba_pkg::used_bytes(num_bytes_reg);
        last_idx = pba_pkg::IDX_W'(n_used - 1'b1);
        mask     = pba_pkg::keep_mask(n_used);
    end

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == pba_pkg::REG_NUM_BYTES);
    assign prdata    = (paddr[2] == pba_pkg::REG_NUM_BYTES)
                       ? {{(pba_pkg::PDATA_W-pba_pkg::NB_W){1'b0}}, num_bytes_reg}
                       : '0;

    // handshakes
    assign item_in.ready  = (state_reg == ST_IDLE);
    assign in_fire        = item_in.valid && item_in.ready;
    assign out_free       = !out_valid_reg || item_out.ready;
    assign item_out.valid        = out_valid_reg;
    assign item_out.result_value = out_value_reg;
    assign item_out.order        = out_order_reg;

    // shared byte unit on the current byte of accumulator and second operand
    assign unit_x         = acc_reg[{idx_reg, 3'b000} +: 8];
    assign unit_y         = opb_reg[{idx_reg, 3'b000} +: 8];
    assign unit_ctrl.is_sub = (cmd_reg == pba_pkg::CMD_SUB);
    assign unit_ctrl.cin    = carry_reg;

    pba_byte_unit u_byte (
        .x    (unit_x),
        .y    (unit_y),
        .ctrl (unit_ctrl),
        .sum  (unit_sum),
        .stat (unit_stat)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        num_bytes_next = cfg_write ? pwdata[pba_pkg::NB_W-1:0] : num_bytes_reg;
        cmd_next       = cmd_reg;
        acc_next       = acc_reg;
        opb_next       = opb_reg;
        idx_next       = idx_reg;
        carry_next     = carry_reg;
        passes_next    = passes_reg;
        ord_next       = ord_reg;
        out_valid_next = out_valid_reg && !item_out.ready;
        out_value_next = out_value_reg;
        out_order_next = out_order_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RUN;
                    cmd_next   = item_in.cmd;
                    acc_next   = item_in.operand_a & mask;
                    idx_next   = '0;
                    carry_next = 1'b0;
                    ord_next   = pba_pkg::ORD_EQUAL;
                    // multiply adds a into the accumulator, so a is the addend
                    if (item_in.cmd == pba_pkg::CMD_MUL)
                    begin
                        opb_next    = item_in.operand_a & mask;
                        passes_next = (item_in.multiplier < 8'd2)
                                      ? '0 : item_in.multiplier - 1'b1;
                    end
                    else
                    begin
                        opb_next    = item_in.operand_b & mask;
                        passes_next = pba_pkg::MULT_W'(1);
                    end
                end
            end
            ST_RUN:
            begin
                if (passes_reg == '0)
                begin
                    // all passes done, hand over once the output slot is free
                    if (out_free)
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b1;
                        out_value_next = acc_reg;
                        out_order_next = ord_reg;
                    end
                end
                else
                begin
                    // one byte through the shared unit
                    if (cmd_reg == pba_pkg::CMD_CMP)
                    begin
                        if (unit_stat.gt)
                            ord_next = pba_pkg::ORD_GREATER;
                        else if (unit_stat.lt)
                            ord_next = pba_pkg::ORD_LESS;
                    end
                    else
                    begin
                        acc_next[{idx_reg, 3'b000} +: 8] = unit_sum;
                    end
                    if (idx_reg == last_idx)
                    begin
                        idx_next    = '0;
                        carry_next  = 1'b0;
                        passes_next = passes_reg - 1'b1;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        carry_next = unit_stat.cout;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_bytes_reg <= pba_pkg::NUM_BYTES_RESET;
            cmd_reg       <= pba_pkg::CMD_ADD;
            acc_reg       <= '0;
            opb_reg       <= '0;
            idx_reg       <= '0;
            carry_reg     <= 1'b0;
            passes_reg    <= '0;
            ord_reg       <= pba_pkg::ORD_EQUAL;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_order_reg <= pba_pkg::ORD_EQUAL;
        end
        else
        begin
            state_reg     <= state_next;
            num_bytes_reg <= num_bytes_next;
            cmd_reg       <= cmd_next;
            acc_reg       <= acc_next;
            opb_reg       <= opb_next;
            idx_reg       <= idx_next;
            carry_reg     <= carry_next;
            passes_reg    <= passes_next;
            ord_reg       <= ord_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_order_reg <= out_order_next;
        end
    end

endmodule
